### sv/rlsp_pkg.sv
// ----------------------------------------------------------------------------
// Read layout parser package
// Shared payload types, status codes, feature codes and parser state.
// ----------------------------------------------------------------------------
package rlsp_pkg;

  localparam int unsigned LEN_W = 8;
  localparam int unsigned POS_W = 10;
  localparam int unsigned MAX_LENGTH = 255;
  localparam int unsigned MAX_POSITION = 1023;

  typedef logic [2:0] status_t;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_DROPPED  = 3'd1;
  localparam status_t ST_COMPLETE = 3'd2;
  localparam status_t ST_EMPTY    = 3'd3;
  localparam status_t ST_BADCHAR  = 3'd4;
  localparam status_t ST_OVERFLOW = 3'd5;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [2:0] {
    FEAT_NONE   = 3'd0,
    FEAT_PRIMER = 3'd1,
    FEAT_TAG    = 3'd2,
    FEAT_BCODE  = 3'd3,
    FEAT_INSERT = 3'd4
  } feature_t;

  localparam logic [7:0] CHAR_P = 8'h50;
  localparam logic [7:0] CHAR_R = 8'h52;
  localparam logic [7:0] CHAR_B = 8'h42;
  localparam logic [7:0] CHAR_N = 8'h4E;
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;

  localparam logic [1:0] SLOT_INSERT = 2'd3;

  typedef struct packed {
    logic       kind;
    logic [7:0] symbol;
  } in_t;

  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] primer_start;
    logic [LEN_W-1:0] primer_length;
    logic [POS_W-1:0] tag_start;
    logic [LEN_W-1:0] tag_length;
    logic [POS_W-1:0] barcode_start;
    logic [LEN_W-1:0] barcode_length;
    logic [POS_W-1:0] insert_primer_start;
    logic [LEN_W-1:0] insert_primer_length;
    logic [POS_W-1:0] insert_start;
  } out_t;

  typedef struct packed {
    logic                        at_beginning;
    feature_t                    pending;
    logic [LEN_W-1:0]            acc;
    logic                        seen;
    logic [POS_W-1:0]            pos;
    status_t                     sticky;
    logic [3:0][POS_W-1:0]       starts;
    logic [3:0][LEN_W-1:0]       lengths;
    logic [POS_W-1:0]            seq_start;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    at_beginning: 1'b1,
    pending:      FEAT_NONE,
    acc:          '0,
    seen:         1'b0,
    pos:          '0,
    sticky:       ST_OK,
    starts:       '0,
    lengths:      '0,
    seq_start:    '0
  };

  function automatic feature_t letter_code(input logic [7:0] c);
    feature_t f;
    case (c)
      CHAR_P:  f = FEAT_PRIMER;
      CHAR_R:  f = FEAT_TAG;
      CHAR_B:  f = FEAT_BCODE;
      CHAR_N:  f = FEAT_INSERT;
      default: f = FEAT_NONE;
    endcase
    return f;
  endfunction

endpackage

### sv/read_layout_spec_parser.sv
// ----------------------------------------------------------------------------
// Read layout parser
// Parses a read layout string one character per request and reports the
// feature layout, or the first error, at the end marker.
// ----------------------------------------------------------------------------
// Pipeline: a request is held in the input register, its result in the
// result register. Throughput: one request per cycle unless output stalls;
// the parser state updates in one pass.
// Reset: synchronous rst clears the valid flags and returns the parser state
// to its initial layout; no clearing pass is needed.
// ----------------------------------------------------------------------------
module read_layout_spec_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rlsp_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output rlsp_pkg::out_t  out_data
);
  import rlsp_pkg::*;

  logic         req_valid;
  in_t          req;
  parse_state_t state;
  parse_state_t state_next;
  out_t         result;
  logic         advance;

  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  rlsp_step u_step (
    .cur  (state),
    .item (req),
    .nxt  (state_next),
    .res  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

### sv/rlsp_step.sv
// ----------------------------------------------------------------------------
// Read layout parser step
// Combinational update of the parser state for one layout character or end
// marker, and the result that the item produces.
// ----------------------------------------------------------------------------
module rlsp_step (
  input  rlsp_pkg::parse_state_t cur,
  input  rlsp_pkg::in_t          item,
  output rlsp_pkg::parse_state_t nxt,
  output rlsp_pkg::out_t         res
);
  import rlsp_pkg::*;

  feature_t               code;
  logic [POS_W:0]         endpos;
  status_t                close_err;
  logic [1:0]             slot;
  parse_state_t           closed;
  status_t                end_err;
  status_t                status;
  logic                   is_digit;
  logic [LEN_W+3:0]       value;

  assign code     = letter_code(item.symbol);
  assign endpos   = {1'b0, cur.pos} + (POS_W+1)'(cur.acc);
  assign slot     = 2'(cur.pending - 3'd1);
  assign is_digit = (item.symbol >= CHAR_0) && (item.symbol <= CHAR_9);
  assign value    = (LEN_W+4)'(cur.acc) * (LEN_W+4)'(10)
                  + (LEN_W+4)'(item.symbol - CHAR_0);

  always_comb begin
    if (cur.pending == FEAT_NONE) begin
      close_err = ST_OK;
    end else if (!cur.seen) begin
      close_err = ST_EMPTY;
    end else if (endpos > (POS_W+1)'(MAX_POSITION)) begin
      close_err = ST_OVERFLOW;
    end else begin
      close_err = ST_OK;
    end
  end

  always_comb begin
    closed = cur;
    if (cur.pending != FEAT_NONE && close_err == ST_OK) begin
      closed.starts[slot]  = cur.pos;
      closed.lengths[slot] = cur.acc;
      closed.pos           = endpos[POS_W-1:0];
      if (slot == SLOT_INSERT) begin
        closed.seq_start = endpos[POS_W-1:0];
      end
    end
  end

  assign end_err = (cur.sticky != ST_OK) ? cur.sticky : close_err;

  always_comb begin
    nxt    = cur;
    res    = '0;
    status = ST_OK;
    if (item.kind == KIND_END) begin
      nxt = STATE_RESET;
      if (end_err != ST_OK) begin
        res.status = end_err;
      end else begin
        res.status               = ST_COMPLETE;
        res.primer_start         = closed.starts[0];
        res.primer_length        = closed.lengths[0];
        res.tag_start            = closed.starts[1];
        res.tag_length           = closed.lengths[1];
        res.barcode_start        = closed.starts[2];
        res.barcode_length       = closed.lengths[2];
        res.insert_primer_start  = closed.starts[3];
        res.insert_primer_length = closed.lengths[3];
        res.insert_start         = closed.seq_start;
      end
    end else if (cur.sticky != ST_OK) begin
      res.status = cur.sticky;
    end else begin
      if (code != FEAT_NONE) begin
        if (cur.pending != FEAT_NONE) begin
          nxt        = closed;
          nxt.sticky = close_err;
        end else if (!cur.at_beginning) begin
          status = ST_DROPPED;
        end
        nxt.pending = code;
        nxt.acc     = '0;
        nxt.seen    = 1'b0;
      end else if (is_digit) begin
        if (cur.pending != FEAT_NONE) begin
          if (value > (LEN_W+4)'(MAX_LENGTH)) begin
            nxt.sticky = ST_OVERFLOW;
          end else begin
            nxt.acc = value[LEN_W-1:0];
          end
          nxt.seen = 1'b1;
        end
      end else begin
        nxt.sticky = ST_BADCHAR;
      end
      nxt.at_beginning = 1'b0;
      res.status = (nxt.sticky != ST_OK) ? nxt.sticky : status;
    end
  end

endmodule

### tb/tb_read_layout_spec_parser.sv
// ----------------------------------------------------------------------------
// Read layout parser testbench
// Drives layout strings through the parser one request at a time and checks
// every result against a cycle-free predictor of the parse. A short directed
// table covers the corner cases. Random layouts follow: most are well formed
// and the rest are noise. Both sides idle at random, with one long output
// stall, one input pause that lets the parser drain, and a quiet tail.
// ----------------------------------------------------------------------------
module tb_read_layout_spec_parser;
  import rlsp_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 1000;
  localparam int unsigned HOLD_FROM = 300;
  localparam int unsigned HOLD_TO = 400;
  localparam int unsigned DRAIN_AT = 600;
  localparam int unsigned QUIET_FROM = 880;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned NUM_PROBES = 25;

  typedef struct packed {
    logic                  fresh;
    feature_t              open_feat;
    logic [LEN_W-1:0]      value;
    logic                  has_digits;
    logic [POS_W-1:0]      cursor;
    status_t               fault;
    logic [3:0][POS_W-1:0] starts;
    logic [3:0][LEN_W-1:0] lens;
    logic [POS_W-1:0]      insert_at;
  } layout_t;

  typedef struct packed {
    in_t     req;
    logic    typed;
    status_t want;
  } probe_t;

  localparam logic [7:0] TYPE_LETTERS [4] = '{CHAR_P, CHAR_R, CHAR_B, CHAR_N};

  localparam probe_t PROBES [NUM_PROBES] = '{
    '{'{KIND_END,  8'h00}, 1'b1, ST_COMPLETE},
    '{'{KIND_CHAR, "9"},   1'b1, ST_OK},
    '{'{KIND_END,  8'hFF}, 1'b1, ST_COMPLETE},
    '{'{KIND_CHAR, "0"},   1'b1, ST_OK},
    '{'{KIND_CHAR, CHAR_P}, 1'b1, ST_DROPPED},
    '{'{KIND_CHAR, "2"},   1'b0, ST_OK},
    '{'{KIND_CHAR, "5"},   1'b0, ST_OK},
    '{'{KIND_CHAR, "5"},   1'b0, ST_OK},
    '{'{KIND_CHAR, CHAR_P}, 1'b0, ST_OK},
    '{'{KIND_CHAR, "9"},   1'b0, ST_OK},
    '{'{KIND_CHAR, CHAR_N}, 1'b0, ST_OK},
    '{'{KIND_CHAR, "0"},   1'b0, ST_OK},
    '{'{KIND_CHAR, CHAR_R}, 1'b0, ST_OK},
    '{'{KIND_CHAR, "1"},   1'b0, ST_OK},
    '{'{KIND_END,  8'h00}, 1'b0, ST_OK},
    '{'{KIND_CHAR, CHAR_B}, 1'b1, ST_OK},
    '{'{KIND_END,  8'h00}, 1'b1, ST_EMPTY},
    '{'{KIND_CHAR, 8'h00}, 1'b1, ST_BADCHAR},
    '{'{KIND_CHAR, 8'hFF}, 1'b1, ST_BADCHAR},
    '{'{KIND_END,  8'h00}, 1'b1, ST_BADCHAR},
    '{'{KIND_CHAR, CHAR_N}, 1'b1, ST_OK},
    '{'{KIND_CHAR, "2"},   1'b1, ST_OK},
    '{'{KIND_CHAR, "5"},   1'b1, ST_OK},
    '{'{KIND_CHAR, "6"},   1'b1, ST_OVERFLOW},
    '{'{KIND_END,  8'h00}, 1'b1, ST_OVERFLOW}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  in_t  in_data = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  layout_t     lay;
  out_t        expected_q[$];
  in_t         layout_q[$];
  int unsigned failures = 0;
  int unsigned cycles = 0;
  int unsigned useful_count = 0;
  int unsigned tx_pct = 0;
  logic        hold_req = 1'b0;
  logic        quiet_tail = 1'b0;

  read_layout_spec_parser u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void restart_layout();
    lay = '0;
    lay.fresh = 1'b1;
  endfunction

  function automatic feature_t letter_feature(input logic [7:0] s);
    feature_t f;
    case (s)
      CHAR_P:  f = FEAT_PRIMER;
      CHAR_R:  f = FEAT_TAG;
      CHAR_B:  f = FEAT_BCODE;
      CHAR_N:  f = FEAT_INSERT;
      default: f = FEAT_NONE;
    endcase
    return f;
  endfunction

  function automatic status_t close_open_feature();
    int unsigned slot;
    int unsigned endpos;
    if (lay.open_feat == FEAT_NONE) return ST_OK;
    if (!lay.has_digits) return ST_EMPTY;
    endpos = lay.cursor + lay.value;
    if (endpos > MAX_POSITION) return ST_OVERFLOW;
    slot = int'(lay.open_feat) - 1;
    lay.starts[slot] = lay.cursor;
    lay.lens[slot] = lay.value;
    lay.cursor = endpos[POS_W-1:0];
    if (lay.open_feat == FEAT_INSERT) lay.insert_at = endpos[POS_W-1:0];
    return ST_OK;
  endfunction

  function automatic out_t predict_layout(input in_t req);
    out_t        res;
    feature_t    f;
    status_t     st;
    status_t     err;
    int unsigned v;
    res = '0;
    st = ST_OK;
    if (req.kind == KIND_END) begin
      if (lay.fault == ST_OK) lay.fault = close_open_feature();
      if (lay.fault != ST_OK) begin
        res.status = lay.fault;
      end else begin
        res.status = ST_COMPLETE;
        res.primer_start = lay.starts[0];
        res.primer_length = lay.lens[0];
        res.tag_start = lay.starts[1];
        res.tag_length = lay.lens[1];
        res.barcode_start = lay.starts[2];
        res.barcode_length = lay.lens[2];
        res.insert_primer_start = lay.starts[3];
        res.insert_primer_length = lay.lens[3];
        res.insert_start = lay.insert_at;
      end
      restart_layout();
      return res;
    end
    if (lay.fault != ST_OK) begin
      res.status = lay.fault;
      return res;
    end
    f = letter_feature(req.symbol);
    if (f != FEAT_NONE) begin
      if (lay.open_feat != FEAT_NONE) begin
        err = close_open_feature();
        if (err != ST_OK) lay.fault = err;
      end else if (!lay.fresh) begin
        st = ST_DROPPED;
      end
      lay.open_feat = f;
      lay.value = '0;
      lay.has_digits = 1'b0;
    end else if (req.symbol >= CHAR_0 && req.symbol <= CHAR_9) begin
      if (lay.open_feat != FEAT_NONE) begin
        v = int'(lay.value) * 10 + int'(req.symbol - CHAR_0);
        if (v > MAX_LENGTH) lay.fault = ST_OVERFLOW;
        else lay.value = v[LEN_W-1:0];
        lay.has_digits = 1'b1;
      end
    end else begin
      lay.fault = ST_BADCHAR;
    end
    lay.fresh = 1'b0;
    res.status = (lay.fault != ST_OK) ? lay.fault : st;
    return res;
  endfunction

  function automatic in_t char_req(input logic [7:0] s);
    in_t r;
    r.kind = KIND_CHAR;
    r.symbol = s;
    return r;
  endfunction

  function automatic void push_digit(input int unsigned d);
    layout_q.push_back(char_req(8'(CHAR_0 + d)));
  endfunction

  function automatic int unsigned pick_pct();
    int unsigned p;
    case ($urandom_range(0, 2))
      0:       p = 0;
      1:       p = 5;
      default: p = 25;
    endcase
    return p;
  endfunction

  // Most layouts are well formed; some run long enough to overflow the
  // running position. The rest are short strings of arbitrary characters.
  task automatic compose_layout();
    int unsigned pick;
    int unsigned nfeat;
    int unsigned v;
    logic        long_run;
    in_t         last;
    layout_q.delete();
    if ($urandom_range(0, 99) < 80) begin
      long_run = ($urandom_range(0, 99) < 15);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) push_digit($urandom_range(0, 9));
      end
      nfeat = long_run ? $urandom_range(5, 8) : $urandom_range(0, 6);
      repeat (nfeat) begin
        layout_q.push_back(char_req(TYPE_LETTERS[$urandom_range(0, 3)]));
        if ($urandom_range(0, 19) != 0) begin
          pick = $urandom_range(0, 99);
          if (long_run) v = $urandom_range(150, 255);
          else if (pick < 60) v = $urandom_range(0, 40);
          else if (pick < 95) v = $urandom_range(41, 255);
          else v = $urandom_range(256, 999);
          if ($urandom_range(0, 9) == 0) push_digit(0);
          if (v >= 100) push_digit(v / 100);
          if (v >= 10) push_digit((v / 10) % 10);
          push_digit(v % 10);
        end
      end
    end else begin
      repeat ($urandom_range(1, 12)) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) layout_q.push_back(char_req(8'($urandom_range(0, 255))));
        else if (pick < 70) layout_q.push_back(char_req(TYPE_LETTERS[$urandom_range(0, 3)]));
        else push_digit($urandom_range(0, 9));
      end
    end
    last.kind = KIND_END;
    last.symbol = 8'($urandom_range(0, 255));
    layout_q.push_back(last);
  endtask

  task automatic offer(input in_t req, input logic typed, input status_t want);
    out_t exp_res;
    logic ignored;
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ignored = (lay.fault != ST_OK) && (req.kind == KIND_CHAR);
    exp_res = predict_layout(req);
    if (typed) begin
      exp_res = '0;
      exp_res.status = want;
    end
    expected_q.push_back(exp_res);
    if (!ignored) useful_count++;
    if (tx_pct != 0 && $urandom_range(1, 100) <= tx_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic match_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  initial begin : stimulus
    logic drained;
    restart_layout();
    drained = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    tx_pct = 10;
    for (int unsigned row = 0; row < NUM_PROBES; row++) begin
      offer(PROBES[row].req, PROBES[row].typed, PROBES[row].want);
    end
    while (useful_count < RANDOM_REQUESTS + NUM_PROBES) begin
      if (useful_count >= QUIET_FROM) begin
        tx_pct = 0;
        quiet_tail <= 1'b1;
      end else if (useful_count >= HOLD_FROM && useful_count < HOLD_TO) begin
        tx_pct = 0;
        hold_req <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        tx_pct = pick_pct();
      end
      if (!drained && useful_count >= DRAIN_AT) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_q.size() != 0);
      end
      compose_layout();
      foreach (layout_q[i]) offer(layout_q[i], 1'b0, ST_OK);
    end
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : receiver
    logic        hold_done;
    int unsigned rx_pct;
    hold_done = 1'b0;
    rx_pct = 10;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!quiet_tail && rx_pct != 0 && $urandom_range(1, 100) <= rx_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
      if ($urandom_range(0, 127) == 0) rx_pct = pick_pct();
    end
  end

  always @(posedge clk) begin : result_check
    out_t want_res;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result with no request waiting: status %0d", out_data.status);
        failures++;
      end else begin
        want_res = expected_q.pop_front();
        match_field("status", want_res.status, out_data.status);
        match_field("primer_start", want_res.primer_start, out_data.primer_start);
        match_field("primer_length", want_res.primer_length, out_data.primer_length);
        match_field("tag_start", want_res.tag_start, out_data.tag_start);
        match_field("tag_length", want_res.tag_length, out_data.tag_length);
        match_field("barcode_start", want_res.barcode_start, out_data.barcode_start);
        match_field("barcode_length", want_res.barcode_length, out_data.barcode_length);
        match_field("insert_primer_start", want_res.insert_primer_start,
                    out_data.insert_primer_start);
        match_field("insert_primer_length", want_res.insert_primer_length,
                    out_data.insert_primer_length);
        match_field("insert_start", want_res.insert_start, out_data.insert_start);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
